// ----- hw/rtl/fba_pkg.sv -----
package fba_pkg;

	localparam int MAX_ENTRIES = 8192;
	localparam int NUM_W       = 14;
	localparam int WORD_W      = 64;
	localparam int BIT_W       = $clog2(WORD_W);
	localparam int MAP_WORDS   = (MAX_ENTRIES + WORD_W - 1) / WORD_W;
	localparam int ADDR_W      = $clog2(MAP_WORDS);
	localparam int IDX_W       = ADDR_W + BIT_W;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] bit_idx;
	} ffz_res_t;

endpackage

// ----- hw/rtl/bitmap_first_free_allocator.sv -----
// First-fit bitmap allocator for one pool of up to 8192 entries, kept as 128 words
// of 64 bits in a RAM with registered read. An allocate scans the map one word per
// cycle through a single find-first-zero unit; a free reads the word and writes it
// back with the bit cleared. An out-of-range free or an allocate on a zero-entry
// pool goes straight to the result. The request port is held off while a request
// is in progress; one finished result can wait in the output register while the
// next request is taken. The map is clear right after reset through per-word valid
// flags, so no clearing pass is needed. The user must write entries_in_use through
// the cfg channel only while the block is idle; the block does not enforce this.
module bitmap_first_free_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [13:0] cfg_data,    // entries_in_use
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // [13:0] entry_number, [15:14] zero
	input  logic [0:0]  s_tuser,     // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata      // [13:0] allocated_number, [15:14] status,
	                                 // [29:16] free_count, [31:30] zero
);
	import fba_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_FRD  = 3'd2;
	localparam logic [2:0] S_FWR  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]           state_q, state_d;
	logic [NUM_W-1:0]     entries_q;
	logic [NUM_W-1:0]     used_q;
	logic [ADDR_W-1:0]    scan_addr_q;
	logic [IDX_W-1:0]     free_idx_q;
	logic                 chk_vld_s1;
	logic [ADDR_W-1:0]    chk_addr_s1;
	logic [MAP_WORDS-1:0] row_vld_q;
	logic [NUM_W-1:0]     res_num_q;
	logic [1:0]           res_status_q;
	logic                 m_tvalid_q;
	logic [31:0]          m_tdata_q;

	logic [NUM_W-1:0]  eff;
	logic [IDX_W-1:0]  eff_m1;
	logic [ADDR_W-1:0] last_word;
	logic [BIT_W-1:0]  last_bit;
	logic [WORD_W-1:0] ram_rdata;
	logic [WORD_W-1:0] chk_word;
	ffz_res_t          ffz;
	logic              in_fire;
	logic              out_free;
	logic              num_bad;
	logic              scan_hit;
	logic              scan_end;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic [NUM_W-1:0]  granted;
	logic [NUM_W-1:0]  free_cnt;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign eff       = (entries_q > NUM_W'(MAX_ENTRIES)) ? NUM_W'(MAX_ENTRIES) : entries_q;
	assign eff_m1    = IDX_W'(eff - NUM_W'(1));
	assign last_word = eff_m1[IDX_W-1:BIT_W];
	assign last_bit  = eff_m1[BIT_W-1:0];

	assign in_fire  = s_tvalid & s_tready;
	assign out_free = ~m_tvalid_q | m_tready;
	assign num_bad  = (s_tdata[NUM_W-1:0] == '0) || (s_tdata[NUM_W-1:0] > eff);

	// words never written since reset read as all clear
	assign chk_word = row_vld_q[chk_addr_s1] ? ram_rdata : '0;

	fba_ffz u_ffz (
		.word     (chk_word),
		.is_last  (chk_addr_s1 == last_word),
		.last_bit (last_bit),
		.res      (ffz)
	);

	assign scan_hit = (state_q == S_SCAN) && chk_vld_s1 && ffz.found;
	assign scan_end = (state_q == S_SCAN) && chk_vld_s1 && !ffz.found
	                  && (chk_addr_s1 == last_word);
	assign granted  = NUM_W'({chk_addr_s1, ffz.bit_idx}) + NUM_W'(1);
	assign free_cnt = (eff > used_q) ? (eff - used_q) : '0;

	assign rd_en   = (state_q == S_SCAN) || (state_q == S_FRD);
	assign rd_addr = (state_q == S_SCAN) ? scan_addr_q : free_idx_q[IDX_W-1:BIT_W];
	assign wr_en   = scan_hit || (state_q == S_FWR);
	assign wr_addr = chk_addr_s1;
	assign wr_data = scan_hit ? (chk_word | (WORD_W'(1) << ffz.bit_idx))
	                          : (chk_word & ~(WORD_W'(1) << free_idx_q[BIT_W-1:0]));

	fba_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (s_tuser[0] == OP_ALLOC) begin
						state_d = (eff == '0) ? S_DONE : S_SCAN;
					end else begin
						state_d = num_bad ? S_DONE : S_FRD;
					end
				end
			end
			S_SCAN: begin
				if (scan_hit || scan_end) begin
					state_d = S_DONE;
				end
			end
			S_FRD:  state_d = S_FWR;
			S_FWR:  state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			entries_q   <= NUM_W'(8192);
			used_q      <= '0;
			scan_addr_q <= '0;
			chk_vld_s1  <= 1'b0;
			row_vld_q   <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			chk_vld_s1 <= (state_q == S_SCAN) && (state_d == S_SCAN);
			if (cfg_valid && cfg_ready) begin
				entries_q <= cfg_data;
			end
			if (state_q == S_IDLE) begin
				scan_addr_q <= '0;
			end else if (state_q == S_SCAN) begin
				scan_addr_q <= scan_addr_q + ADDR_W'(1);
			end
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (scan_hit && (used_q != {NUM_W{1'b1}})) begin
				used_q <= used_q + NUM_W'(1);
			end else if ((state_q == S_FWR) && (used_q != '0)) begin
				used_q <= used_q - NUM_W'(1);
			end
			if ((state_q == S_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload: no reset
	always_ff @(posedge clk) begin
		if (rd_en) begin
			chk_addr_s1 <= rd_addr;
		end
		if (in_fire) begin
			free_idx_q   <= IDX_W'(s_tdata[NUM_W-1:0] - NUM_W'(1));
			res_num_q    <= '0;
			if (s_tuser[0] == OP_ALLOC) begin
				res_status_q <= (eff == '0) ? ST_FULL : ST_OK;
			end else begin
				res_status_q <= num_bad ? ST_RANGE : ST_OK;
			end
		end
		if (scan_hit) begin
			res_num_q <= granted;
		end
		if (scan_end) begin
			res_status_q <= ST_FULL;
		end
		if ((state_q == S_DONE) && out_free) begin
			m_tdata_q <= {2'b00, free_cnt, res_status_q, res_num_q};
		end
	end

`ifndef SYNTHESIS
	a_wr_in_owner: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_SCAN) || (state_q == S_FWR))
		else $error("map written outside scan or free write");

	a_chk_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chk_vld_s1 |-> (state_q == S_SCAN))
		else $error("scan compare active outside scan");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q != S_IDLE))
		else $error("request accepted but sequencer stayed idle");

	a_no_grant_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[15:14] != ST_OK)) |-> (m_tdata[13:0] == '0))
		else $error("nonzero entry number with error status");
`endif

endmodule

// ----- hw/rtl/fba_ram.sv -----
module fba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/fba_ffz.sv -----
module fba_ffz (
	input  logic [fba_pkg::WORD_W-1:0] word,
	input  logic                       is_last,
	input  logic [fba_pkg::BIT_W-1:0]  last_bit,
	output fba_pkg::ffz_res_t          res
);
	import fba_pkg::*;

	logic [WORD_W-1:0] keep;
	logic [WORD_W-1:0] free_bits;
	logic [WORD_W-1:0] lowest;

	// bits above the pool limit in the last word count as taken
	assign keep      = is_last ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - last_bit))
	                           : {WORD_W{1'b1}};
	assign free_bits = ~word & keep;
	assign lowest    = free_bits & (~free_bits + WORD_W'(1));

	always_comb begin
		res.found   = |free_bits;
		res.bit_idx = '0;
		for (int k = 0; k < BIT_W; k++) begin
			for (int b = 0; b < WORD_W; b++) begin
				if (((b >> k) & 1) == 1) begin
					res.bit_idx[k] = res.bit_idx[k] | lowest[b];
				end
			end
		end
	end

endmodule
